// File: hw/rtl/kms_pkg.sv
// ----------------------------------------------------------------------------
// kms_pkg
// Shared constants, CSR indexes and state type for the k-mer minimizer core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kms_pkg;

   localparam int KMER_BITS = 32;
   localparam int OUT_BITS  = 32;
   localparam int BASE_W    = 3;
   localparam int K_W       = 5;
   localparam int W_W       = 7;
   localparam int RUN_W     = 5;
   localparam int CSR_W     = 7;
   localparam int CSR_IDX_W = 1;
   localparam int REQ_DW    = 8;
   localparam int RSP_DW    = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_KMER_LENGTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_KMERS = 1'b1;

   localparam logic [K_W-1:0]    K_RESET   = 5'd15;
   localparam logic [K_W-1:0]    K_MAX     = 5'd16;
   localparam logic [W_W-1:0]    W_RESET   = 7'd10;
   localparam logic [BASE_W-1:0] BASE_LAST = 3'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BACK,
      ST_FRONT
   } kms_state_type;

endpackage

// File: hw/rtl/kms_deque_ram.sv
// ----------------------------------------------------------------------------
// kms_deque_ram
// Deque storage: one write port, two registered read ports with write-first
// forwarding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kms_deque_ram #(
   parameter int WIDTH = 64,
   parameter int AW    = 7
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    ra_addr,
   input  logic [AW-1:0]    rb_addr,
   output logic [WIDTH-1:0] ra_data,
   output logic [WIDTH-1:0] rb_data
);

   logic [WIDTH-1:0] mem_ff [2**AW];
   logic [WIDTH-1:0] ra_data_ff;
   logic [WIDTH-1:0] rb_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // forward a same-cycle write to either read port
   always_ff @(posedge clock) begin
      if (we && (waddr == ra_addr)) begin
         ra_data_ff <= wdata;
      end else begin
         ra_data_ff <= mem_ff[ra_addr];
      end
      if (we && (waddr == rb_addr)) begin
         rb_data_ff <= wdata;
      end else begin
         rb_data_ff <= mem_ff[rb_addr];
      end
   end

   assign ra_data = ra_data_ff;
   assign rb_data = rb_data_ff;

endmodule

// File: hw/rtl/kmer_minimizer_stream_core.sv
// ----------------------------------------------------------------------------
// kmer_minimizer_stream_core
// A base that completes no k-mer is taken in ST_IDLE alone; one that does
// then pops larger entries off the deque back in ST_BACK, pushes itself, and
// ages entries out of the front in ST_FRONT, where a base with a result also
// waits on rsp_tready while an earlier result beat is pending. One base in
// flight at a time; a result beat appears on rsp the cycle after its base finishes.
// Reset (synchronous): k = 15, w = 10, counters and deque fill count cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kmer_minimizer_stream_core #(
   parameter int MAX_WINDOW = 64,
   parameter int POS_BITS   = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: base_code[2:0], zero fill
   input  logic [kms_pkg::REQ_DW-1:0]      req_tdata,
   // req_tuser: first_of_sequence
   input  logic                            req_tuser,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // rsp_tdata: minimizer_value[31:0], minimizer_start[63:32]
   output logic [kms_pkg::RSP_DW-1:0]      rsp_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            csr_we,
   input  logic [kms_pkg::CSR_IDX_W-1:0]   csr_addr,
   input  logic [kms_pkg::CSR_W-1:0]       csr_wdata
);

   import kms_pkg::*;

   localparam int AW = $clog2(MAX_WINDOW + 1);
   localparam int CW = $clog2(MAX_WINDOW + 2);
   localparam int EW = KMER_BITS + POS_BITS;
   localparam logic [W_W-1:0] W_CAP =
      (MAX_WINDOW > 127) ? {W_W{1'b1}} : W_W'(MAX_WINDOW);
   localparam logic [CW-1:0] CNT_LIMIT = CW'(MAX_WINDOW + 1);

   kms_state_type state_ff, state_in;

   logic [K_W-1:0]        k_ff;
   logic [W_W-1:0]        w_ff;
   logic [KMER_BITS-1:0]  kmer_ff, kmer_in;
   logic [RUN_W-1:0]      run_ff, run_in;
   logic [W_W-1:0]        proc_ff, proc_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic [POS_BITS-1:0]   last_ff, last_in;
   logic                  seen_ff, seen_in;
   logic [AW-1:0]         head_ff, head_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DW-1:0]     rsp_data_ff, rsp_data_in;

   logic [K_W-1:0]        k_eff;
   logic [W_W-1:0]        w_eff;
   logic [KMER_BITS-1:0]  kmer_mask;
   logic [BASE_W-1:0]     code;
   logic                  first;
   logic                  accept;

   logic [KMER_BITS-1:0]  kmer_base;
   logic [RUN_W-1:0]      run_base;
   logic [W_W-1:0]        proc_base;
   logic [POS_BITS-1:0]   pos_base;
   logic [POS_BITS-1:0]   last_base;
   logic                  seen_base;
   logic [CW-1:0]         cnt_base;
   logic [RUN_W-1:0]      run_next;
   logic [KMER_BITS-1:0]  kmer_next;

   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [EW-1:0]         mem_wdata;
   logic [AW-1:0]         ra_addr;
   logic [AW-1:0]         rb_addr;
   logic [EW-1:0]         ra_data;
   logic [EW-1:0]         rb_data;

   logic [KMER_BITS-1:0]  back_value;
   logic [KMER_BITS-1:0]  front_value;
   logic [POS_BITS-1:0]   front_pos;
   logic [POS_BITS-1:0]   age;
   logic                  age_hit;
   logic [W_W-1:0]        proc_sat;
   logic                  win_full;
   logic [POS_BITS-1:0]   start;
   logic                  emit_want;

   // clamp configuration
   assign k_eff = (k_ff == '0) ? K_W'(1) : ((k_ff > K_MAX) ? K_MAX : k_ff);
   assign w_eff = (w_ff == '0) ? W_W'(1) : ((w_ff > W_CAP) ? W_CAP : w_ff);
   assign kmer_mask = ~({KMER_BITS{1'b1}} << {k_eff, 1'b0});

   assign code   = req_tdata[BASE_W-1:0];
   assign first  = req_tuser;
   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // state as seen by this beat, after a start-of-sequence clear
   assign kmer_base = first ? '0 : kmer_ff;
   assign run_base  = first ? '0 : run_ff;
   assign proc_base = first ? '0 : proc_ff;
   assign pos_base  = first ? '0 : pos_ff;
   assign last_base = first ? '0 : last_ff;
   assign seen_base = first ? 1'b0 : seen_ff;
   assign cnt_base  = first ? '0 : cnt_ff;

   assign run_next  = (run_base == {RUN_W{1'b1}}) ? run_base : run_base + RUN_W'(1);
   assign kmer_next = ({kmer_base[KMER_BITS-3:0], 2'b00} |
                       {{(KMER_BITS-2){1'b0}}, code[1:0]}) & kmer_mask;

   assign back_value  = ra_data[KMER_BITS-1:0];
   assign front_value = rb_data[KMER_BITS-1:0];
   assign front_pos   = rb_data[EW-1:KMER_BITS];
   assign age         = pos_ff - front_pos;
   assign age_hit     = age >= POS_BITS'(w_eff);
   assign proc_sat    = (proc_ff == {W_W{1'b1}}) ? proc_ff : proc_ff + W_W'(1);
   assign win_full    = proc_sat >= w_eff;
   assign start       = front_pos - POS_BITS'(k_eff) + POS_BITS'(1);
   assign emit_want   = win_full && (!seen_ff || (start != last_ff));

   always_comb begin
      state_in     = state_ff;
      kmer_in      = kmer_ff;
      run_in       = run_ff;
      proc_in      = proc_ff;
      pos_in       = pos_ff;
      last_in      = last_ff;
      seen_in      = seen_ff;
      head_in      = head_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = head_ff + cnt_ff[AW-1:0];
      mem_wdata    = {pos_ff, kmer_ff};
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kmer_in = kmer_base;
               proc_in = proc_base;
               last_in = last_base;
               seen_in = seen_base;
               cnt_in  = cnt_base;
               pos_in  = pos_base + POS_BITS'(1);
               if (code <= BASE_LAST) begin
                  run_in  = run_next;
                  kmer_in = kmer_next;
                  if (run_next >= k_eff) begin
                     pos_in   = pos_base;
                     state_in = ST_BACK;
                  end
               end else begin
                  run_in = '0;
               end
            end
         end
         ST_BACK: begin
            // drop larger entries off the back, then push
            if ((cnt_ff != '0) && (back_value > kmer_ff)) begin
               cnt_in = cnt_ff - CW'(1);
            end else begin
               mem_we   = 1'b1;
               cnt_in   = cnt_ff + CW'(1);
               state_in = ST_FRONT;
            end
         end
         ST_FRONT: begin
            if (age_hit) begin
               head_in = head_ff + AW'(1);
               cnt_in  = cnt_ff - CW'(1);
            end else if (!emit_want || !rsp_valid_ff || rsp_tready) begin
               proc_in = proc_sat;
               if (win_full) begin
                  last_in = start;
                  seen_in = 1'b1;
               end
               if (emit_want) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {OUT_BITS'(start), front_value};
               end
               pos_in   = pos_ff + POS_BITS'(1);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign ra_addr = head_in + cnt_in[AW-1:0] - AW'(1);
   assign rb_addr = head_in;

   kms_deque_ram #(
      .WIDTH (EW),
      .AW    (AW)
   ) u_deque (
      .clock   (clock),
      .we      (mem_we),
      .waddr   (mem_waddr),
      .wdata   (mem_wdata),
      .ra_addr (ra_addr),
      .rb_addr (rb_addr),
      .ra_data (ra_data),
      .rb_data (rb_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= K_RESET;
         w_ff <= W_RESET;
      end else if (csr_we) begin
         if (csr_addr == CSR_KMER_LENGTH) begin
            k_ff <= csr_wdata[K_W-1:0];
         end else if (csr_addr == CSR_WINDOW_KMERS) begin
            w_ff <= csr_wdata[W_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         kmer_ff      <= '0;
         run_ff       <= '0;
         proc_ff      <= '0;
         pos_ff       <= '0;
         last_ff      <= '0;
         seen_ff      <= 1'b0;
         head_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kmer_ff      <= kmer_in;
         run_ff       <= run_in;
         proc_ff      <= proc_in;
         pos_ff       <= pos_in;
         last_ff      <= last_in;
         seen_ff      <= seen_in;
         head_ff      <= head_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_LIMIT)
      else $error("deque fill count above capacity");

   a_front_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FRONT) |-> (cnt_ff != '0))
      else $error("front check on empty deque");

   a_age_keeps_new: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FRONT) && age_hit) |-> (cnt_ff > CW'(1)))
      else $error("aging would drop the newest entry");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FRONT))
      else $error("result beat raised outside front stage");

endmodule
